### hdl/sor_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOR stencil sweep package
// Shared constants, request and response types, register indexes and the
// sequencer states of the successive over-relaxation stencil sweep.
// ----------------------------------------------------------------------------
package sor_pkg;

   // Grid geometry: interior columns plus the two ghost columns.
   localparam int MAX_COLS   = 1024;
   localparam int ROW_SLOTS  = MAX_COLS + 2;
   localparam int COL_W      = $clog2(ROW_SLOTS);

   // Register widths.
   localparam int COLS_REG_W  = 11;
   localparam int ROWS_REG_W  = 16;
   localparam int OMEGA_W     = 18;
   localparam int OMEGA_FRAC  = 16;
   localparam int ROW_W       = ROWS_REG_W + 1;

   // Cell values and the arithmetic built on them.
   localparam int VALUE_W     = 32;
   localparam int NORM_W      = 64;
   localparam int SUM_W       = VALUE_W + 2;
   localparam int D_W         = VALUE_W + 3;
   localparam int MUL_A_W     = D_W;
   localparam int MUL_B_W     = VALUE_W + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int W_PROD_W    = D_W + OMEGA_W + 1;
   localparam int SHIFT       = OMEGA_FRAC + 2;
   localparam int ROUND_BIAS  = 1 << (SHIFT - 1);
   localparam int Q_W         = W_PROD_W - SHIFT;
   localparam int S_W         = Q_W + 1;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = OMEGA_W;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OMEGA     = 2'd2;

   // Register reset values.
   localparam logic [COLS_REG_W-1:0] GRID_COLS_RESET = 11'd1024;
   localparam logic [ROWS_REG_W-1:0] GRID_ROWS_RESET = 16'd1024;
   localparam logic [OMEGA_W-1:0]    OMEGA_RESET     = 18'd65536;

   typedef struct packed {
      logic signed [VALUE_W-1:0] cell_value;
      logic                      last_cell;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] new_value;
      logic                      last_result;
      logic [NORM_W-1:0]         norm_sum;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_OLD,
      ST_RD_RIGHT,
      ST_RD_LEFT,
      ST_SUM,
      ST_MUL_W,
      ST_ROUND,
      ST_DIFF,
      ST_MUL_SQ,
      ST_ACC,
      ST_COMMIT
   } state_type;

endpackage

### hdl/sor_stencil_sweep_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SOR stencil sweep
// Streams an old grid, halo included, and returns the relaxed interior cells
// of one successive over-relaxation sweep with a five-point stencil.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake           Carries
//   req_      in         req_valid/req_stall old cell and last-cell flag
//   rsp_      out        rsp_valid/rsp_stall new value, last flag, norm
//   csr_      in         csr_valid/csr_ready register index and data
//
// A halo cell or any cell that yields no result goes straight to commit. An
// interior cell takes three reads through the single read port of the old
// row store, one sum, the shared multiplier used twice (weighting, then the
// squared change) with a rounding step and a difference step between.
// Reset is synchronous; the row stores hold no reset value and need no
// clearing pass. A stalled response holds the sequencer in its commit step when the cell has a result.
// ----------------------------------------------------------------------------
module sor_stencil_sweep_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sor_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sor_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sor_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sor_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sor_pkg::*;

   // Configuration registers.
   logic [COLS_REG_W-1:0]      grid_cols_ff;
   logic [ROWS_REG_W-1:0]      grid_rows_ff;
   logic [OMEGA_W-1:0]         omega_ff;

   // Sequencer and sweep state.
   state_type                  state_ff, state_in;
   logic [ROW_W-1:0]           row_ff, row_in;
   logic [COL_W-1:0]           col_ff, col_in;
   logic [NORM_W-1:0]          acc_ff, acc_in;
   logic signed [VALUE_W-1:0]  new_left_ff;

   // Captured request and working registers.
   logic signed [VALUE_W-1:0]  cell_ff;
   logic                       last_ff;
   logic                       interior_ff;
   logic signed [VALUE_W-1:0]  old_val_ff;
   logic signed [VALUE_W-1:0]  right_ff;
   logic signed [VALUE_W-1:0]  old_q_ff;
   logic signed [VALUE_W-1:0]  new_q_ff;
   logic signed [D_W-1:0]      d_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [VALUE_W-1:0]  nv_ff;
   logic [VALUE_W-1:0]         mag_ff;

   // Response register.
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff;

   // Row stores: two old rows used in turn and one new row.
   logic signed [VALUE_W-1:0]  old_mem [2][ROW_SLOTS];
   logic signed [VALUE_W-1:0]  new_mem [ROW_SLOTS];

   // Combinational signals.
   logic [COL_W-1:0]           cols_eff, cols_p1;
   logic [ROW_W-1:0]           rows_eff, rows_p1;
   logic                       accept, interior, commit, load_rsp, fin, sweep_end;
   logic                       old_rd_en, new_rd_en;
   logic [COL_W-1:0]           old_rd_col;
   logic                       mul_en;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic signed [VALUE_W-1:0]  left_val;
   logic signed [SUM_W-1:0]    sum4;
   logic signed [D_W-1:0]      d_calc;
   logic signed [W_PROD_W-1:0] t_val;
   logic signed [Q_W-1:0]      q_val;
   logic signed [S_W-1:0]      s_val;
   logic                       s_fits;
   logic signed [VALUE_W-1:0]  nv_calc;
   logic signed [VALUE_W:0]    diff_val, diff_abs;
   logic [NORM_W:0]            acc_sum;

   // Register bounds as the sweep uses them.
   always_comb begin
      if (grid_cols_ff == '0) begin
         cols_eff = COL_W'(1);
      end else if (32'(grid_cols_ff) > 32'(MAX_COLS)) begin
         cols_eff = COL_W'(MAX_COLS);
      end else begin
         cols_eff = COL_W'(grid_cols_ff);
      end
      rows_eff = (grid_rows_ff == '0) ? ROW_W'(1) : ROW_W'(grid_rows_ff);
      cols_p1  = cols_eff + COL_W'(1);
      rows_p1  = rows_eff + ROW_W'(1);
   end

   assign accept    = req_valid && !req_stall;
   assign interior  = (row_ff >= ROW_W'(2)) && (row_ff <= rows_p1) &&
                      (col_ff >= COL_W'(1)) && (col_ff <= cols_eff);
   assign fin       = interior_ff && (row_ff == rows_p1) && (col_ff == cols_eff);
   assign sweep_end = last_ff || ((row_ff >= rows_p1) && (col_ff >= cols_p1));

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= GRID_COLS_RESET;
         grid_rows_ff <= GRID_ROWS_RESET;
         omega_ff     <= OMEGA_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRID_COLS: grid_cols_ff <= csr_data[COLS_REG_W-1:0];
            CSR_GRID_ROWS: grid_rows_ff <= csr_data[ROWS_REG_W-1:0];
            CSR_OMEGA:     omega_ff     <= csr_data[OMEGA_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: next state and control.
   always_comb begin
      state_in     = state_ff;
      req_stall    = (state_ff != ST_IDLE);
      old_rd_en    = 1'b0;
      old_rd_col   = col_ff;
      new_rd_en    = 1'b0;
      mul_en       = 1'b0;
      commit       = 1'b0;
      mul_a        = d_ff;
      mul_b        = signed'(MUL_B_W'(omega_ff));
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = interior ? ST_RD_OLD : ST_COMMIT;
            end
         end
         ST_RD_OLD: begin
            old_rd_en = 1'b1;
            new_rd_en = 1'b1;
            state_in  = ST_RD_RIGHT;
         end
         ST_RD_RIGHT: begin
            old_rd_en  = 1'b1;
            old_rd_col = col_ff + COL_W'(1);
            state_in   = ST_RD_LEFT;
         end
         ST_RD_LEFT: begin
            old_rd_en  = 1'b1;
            old_rd_col = '0;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_MUL_W;
         end
         ST_MUL_W: begin
            mul_en   = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            state_in = ST_MUL_SQ;
         end
         ST_MUL_SQ: begin
            mul_en   = 1'b1;
            mul_a    = signed'(MUL_A_W'(mag_ff));
            mul_b    = signed'(MUL_B_W'(mag_ff));
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // A result waits here until the response register is free.
            if (!(interior_ff && rsp_valid_ff && rsp_stall)) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Shared multiplier.
   assign mul_p = mul_a * mul_b;

   // Stencil sum and the difference from four times the old value.
   always_comb begin
      left_val = (col_ff == COL_W'(1)) ? old_q_ff : new_left_ff;
      sum4     = SUM_W'(left_val) + SUM_W'(right_ff) + SUM_W'(new_q_ff) +
                 SUM_W'(cell_ff);
      d_calc   = D_W'(sum4) - (D_W'(old_val_ff) <<< 2);
   end

   // Round half up, add to the old value and saturate.
   always_comb begin
      t_val   = signed'(prod_ff[W_PROD_W-1:0]) + W_PROD_W'(ROUND_BIAS);
      q_val   = t_val[W_PROD_W-1:SHIFT];
      s_val   = S_W'(q_val) + S_W'(old_val_ff);
      s_fits  = (s_val[S_W-1:VALUE_W-1] == '0) || (s_val[S_W-1:VALUE_W-1] == '1);
      if (s_fits) begin
         nv_calc = s_val[VALUE_W-1:0];
      end else if (s_val[S_W-1]) begin
         nv_calc = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         nv_calc = {1'b0, {(VALUE_W-1){1'b1}}};
      end
   end

   // Magnitude of the change.
   always_comb begin
      diff_val = (VALUE_W+1)'(nv_ff) - (VALUE_W+1)'(old_val_ff);
      diff_abs = diff_val[VALUE_W] ? -diff_val : diff_val;
   end

   // Saturating accumulation of the squared change and sweep restart.
   always_comb begin
      acc_sum = {1'b0, acc_ff} + {1'b0, prod_ff[NORM_W-1:0]};
      acc_in  = acc_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (state_ff == ST_ACC) begin
         acc_in = acc_sum[NORM_W] ? '1 : acc_sum[NORM_W-1:0];
      end
      if (commit) begin
         if (sweep_end) begin
            row_in = '0;
            col_in = '0;
            acc_in = '0;
         end else if (col_ff >= cols_p1) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         acc_ff      <= '0;
         new_left_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         acc_ff <= acc_in;
         if (commit && interior_ff) begin
            new_left_ff <= nv_ff;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         cell_ff     <= req_data.cell_value;
         last_ff     <= req_data.last_cell;
         interior_ff <= interior;
      end
      if (state_ff == ST_RD_RIGHT) begin
         old_val_ff <= old_q_ff;
      end
      if (state_ff == ST_RD_LEFT) begin
         right_ff <= old_q_ff;
      end
      if (state_ff == ST_SUM) begin
         d_ff <= d_calc;
      end
      if (mul_en) begin
         prod_ff <= mul_p;
      end
      if (state_ff == ST_ROUND) begin
         nv_ff <= nv_calc;
      end
      if (state_ff == ST_DIFF) begin
         mag_ff <= diff_abs[VALUE_W-1:0];
      end
   end

   // Old row store: the row above is read, the incoming row is written.
   always_ff @(posedge clock) begin
      if (old_rd_en) begin
         old_q_ff <= old_mem[~row_ff[0]][old_rd_col];
      end
      if (commit) begin
         old_mem[row_ff[0]][col_ff] <= cell_ff;
      end
   end

   // New row store: the top ghost row, then the relaxed values.
   always_ff @(posedge clock) begin
      if (new_rd_en) begin
         new_q_ff <= new_mem[col_ff];
      end
      if (commit && (row_ff == '0)) begin
         new_mem[col_ff] <= cell_ff;
      end else if (commit && interior_ff) begin
         new_mem[col_ff] <= nv_ff;
      end
   end

   // Response register.
   assign load_rsp = commit && interior_ff;

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff.new_value   <= nv_ff;
         rsp_data_ff.last_result <= fin;
         rsp_data_ff.norm_sum    <= fin ? acc_ff : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // An accepted request always starts the sequencer.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted request did not start the sequencer");

   // The norm is only carried by the last result of a sweep.
   a_norm_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.last_result) |-> (rsp_data_ff.norm_sum == '0))
      else $error("norm sum present on a result that is not the last");

   // The accumulator is clear whenever a sweep starts.
   a_acc_clear_at_start: assert property (@(posedge clock) disable iff (reset)
      ((row_ff == '0) && (col_ff == '0)) |-> (acc_ff == '0))
      else $error("accumulator not clear at the start of a sweep");

   // A response only appears from the commit step.
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_COMMIT))
      else $error("response raised outside the commit step");
`endif

endmodule
